// ===== hw/rtl/sai_pkg.sv =====
// ----------------------------------------------------------------------------
// sai_pkg
// Shared constants and codes for the string atom interner.
// ----------------------------------------------------------------------------
`default_nettype none
package sai_pkg;
  localparam int MAX_STRING_BYTES_DEF = 255;
  localparam int MAX_ATOMS_DEF        = 187;
  localparam int FIRST_ID_DEF         = 64;
  localparam int POOL_BYTES_DEF       = 8192;

  localparam logic [13:0] POOL_LIMIT_RESET = 14'd6144;
  localparam logic [7:0]  SPACE_BYTE       = 8'h20;

  localparam logic [2:0] OP_APPEND     = 3'd0;
  localparam logic [2:0] OP_TRIM       = 3'd1;
  localparam logic [2:0] OP_INTERN     = 3'd2;
  localparam logic [2:0] OP_RESET_POOL = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  localparam logic [2:0] ST_FOUND      = 3'd0;
  localparam logic [2:0] ST_ADDED      = 3'd1;
  localparam logic [2:0] ST_TOO_LONG   = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_POOL_FULL  = 3'd5;
endpackage
`default_nettype wire

// ===== hw/rtl/string_atom_interner.sv =====
// ----------------------------------------------------------------------------
// string_atom_interner
// Builder buffer plus interning table over a packed byte pool.
// ----------------------------------------------------------------------------
// Appends, clears and pool resets are done from the idle state on acceptance.
// Trim and intern are run by a sequencer over the builder, offset and pool
// memories (one registered read port each). Trim scans trailing spaces, then
// leading spaces, then shifts the remaining bytes down. Intern reads the end
// offsets of each atom, compares each same-length candidate byte by byte,
// then reads the free offset and copies a new string into the pool; a
// too-long or empty answer is out the cycle after the request. Input ready
// is low while the sequencer is busy and while a result waits unaccepted;
// a new request can enter in the cycle the old result leaves. Offset entry
// zero is cleared while reset is held, so no clearing pass follows reset.
`default_nettype none
module string_atom_interner #(
  parameter int MAX_STRING_BYTES = sai_pkg::MAX_STRING_BYTES_DEF,
  parameter int MAX_ATOMS        = sai_pkg::MAX_ATOMS_DEF,
  parameter int FIRST_ID         = sai_pkg::FIRST_ID_DEF,
  parameter int POOL_BYTES       = sai_pkg::POOL_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [13:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       atom_id,
  output logic [2:0]       status,
  output logic [15:0]      size_reported
);
  import sai_pkg::*;

  localparam int LW = 8;                       // builder length width
  localparam int BW = $clog2(MAX_STRING_BYTES);
  localparam int PW = $clog2(POOL_BYTES);
  localparam int OW = PW + 1;                  // offsets reach POOL_BYTES
  localparam int AW = $clog2(MAX_ATOMS + 1);
  localparam int CW = 8;

  localparam logic [3:0] S_IDLE = 4'd0, S_TB = 4'd1, S_TF = 4'd2, S_SH = 4'd3,
    S_IA = 4'd4, S_IB = 4'd5, S_IC = 4'd6, S_CMP = 4'd7, S_CPY = 4'd8,
    S_FIN = 4'd9, S_TBW = 4'd10, S_TFW = 4'd11;

  // memories
  logic [7:0]    bmem [MAX_STRING_BYTES];
  logic [OW-1:0] omem [MAX_ATOMS + 1];
  logic [7:0]    pmem [POOL_BYTES];

  logic [3:0]    state;
  logic [13:0]   pool_limit;
  logic [LW-1:0] blen;
  logic          bovf;
  logic [15:0]   pushed;
  logic [CW-1:0] acount;

  // builder port
  logic          b_we;
  logic [BW-1:0] b_wa, b_ra;
  logic [7:0]    b_wd, b_rd;
  // offset port
  logic          o_we;
  logic [AW-1:0] o_wa, o_ra;
  logic [OW-1:0] o_wd, o_rd;
  // pool port
  logic          p_we;
  logic [PW-1:0] p_wa, p_ra;
  logic [7:0]    p_wd, p_rd;

  always_ff @(posedge clk) begin
    if (b_we) bmem[b_wa] <= b_wd;
    b_rd <= bmem[b_ra];
    if (o_we) omem[o_wa] <= o_wd;
    o_rd <= omem[o_ra];
    if (p_we) pmem[p_wa] <= p_wd;
    p_rd <= pmem[p_ra];
  end

  // sequencer registers
  logic [LW:0]   k;        // byte index
  logic [LW-1:0] lead;
  logic [CW-1:0] ai;       // atom index
  logic [OW-1:0] start, endo;
  logic          rd_pend;

  wire accept = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready);

  // intern answered straight from the idle state (too long or empty)
  wire quick_give = accept && opcode == OP_INTERN && (bovf || blen == '0);

  logic [OW-1:0] limit_eff;
  assign limit_eff = (32'(pool_limit) > POOL_BYTES) ? OW'(POOL_BYTES)
                                                    : OW'(pool_limit);

  logic [OW-1:0] len_o;
  assign len_o = OW'(blen);
  logic [OW:0] need;
  assign need = {1'b0, start} + {1'b0, len_o};

  // memory addressing
  always_comb begin
    b_we = 1'b0; b_wa = '0; b_wd = data_byte; b_ra = '0;
    o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = AW'(ai);
    p_we = 1'b0; p_wa = '0; p_wd = b_rd; p_ra = '0;
    if (rst) begin
      o_we = 1'b1; o_wa = '0; o_wd = '0;
    end
    if (accept && opcode == OP_APPEND && 32'(blen) < MAX_STRING_BYTES) begin
      b_we = 1'b1; b_wa = BW'(blen);
    end
    if (accept && opcode == OP_RESET_POOL) begin
      o_we = 1'b1; o_wa = '0; o_wd = '0;
    end
    unique case (state)
      S_TB, S_TBW: b_ra = BW'(blen - 1'b1);
      S_TF, S_TFW: b_ra = BW'(lead);
      S_SH: begin
        b_ra = BW'(k[LW-1:0] + lead);
        if (rd_pend) begin
          b_we = 1'b1; b_wa = BW'(k[LW-1:0] - 1'b1); b_wd = b_rd;
        end
      end
      S_IA: o_ra = AW'(ai);
      S_IB: o_ra = AW'(ai + 1'b1);
      S_CMP: begin
        b_ra = BW'(k[LW-1:0]);
        p_ra = PW'(start + OW'(k));
      end
      S_CPY: begin
        b_ra = BW'(k[LW-1:0]);
        if (rd_pend) begin
          p_we = 1'b1; p_wa = PW'(start + OW'(k) - 1'b1);
        end
        if (k == len_o[LW:0] + 1'b1) begin
          o_we = 1'b1; o_wa = AW'(acount + 1'b1); o_wd = need[OW-1:0];
        end
      end
      default: ;
    endcase
  end

  task automatic give(input logic [7:0] id, input logic [2:0] st,
                      input logic [15:0] sz);
    out_valid     <= 1'b1;
    atom_id       <= id;
    status        <= st;
    size_reported <= sz;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pool_limit <= POOL_LIMIT_RESET;
      blen       <= '0;
      bovf       <= 1'b0;
      pushed     <= '0;
      acount     <= '0;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      if (cfg_we) pool_limit <= cfg_wdata;
      if (out_valid && out_ready && !quick_give) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          priority case (opcode)
            OP_APPEND: begin
              if (pushed != 16'hFFFF) pushed <= pushed + 16'd1;
              if (32'(blen) < MAX_STRING_BYTES) blen <= blen + 1'b1;
              else bovf <= 1'b1;
            end
            OP_TRIM: if (blen != 0) state <= S_TBW;
            OP_INTERN: begin
              if (bovf) give(8'd0, ST_TOO_LONG, pushed);
              else if (blen == 0) give(8'd0, ST_EMPTY, 16'd0);
              else begin ai <= '0; state <= S_IA; end
            end
            OP_RESET_POOL: acount <= '0;
            OP_CLEAR: begin blen <= '0; bovf <= 1'b0; pushed <= '0; end
            default: ;
          endcase
        end
        // trailing spaces: read issued in TBW, checked in TB
        S_TBW: state <= S_TB;
        S_TB: begin
          if (b_rd == SPACE_BYTE) begin
            blen <= blen - 1'b1;
            state <= (blen == 1) ? S_IDLE : S_TBW;
          end else begin
            lead <= '0; state <= S_TFW;
          end
        end
        S_TFW: state <= S_TF;
        S_TF: begin
          if (b_rd == SPACE_BYTE && lead + 1'b1 < blen) begin
            lead <= lead + 1'b1; state <= S_TFW;
          end else if (lead == 0) state <= S_IDLE;
          else begin k <= '0; rd_pend <= 1'b0; state <= S_SH; end
        end
        S_SH: begin
          if (k == {1'b0, blen - lead}) begin
            blen <= blen - lead; rd_pend <= 1'b0; state <= S_IDLE;
          end else begin
            k <= k + 1'b1; rd_pend <= 1'b1;
          end
        end
        // search: IA reads end[ai], IB reads end[ai+1]
        S_IA: begin
          if (ai == acount || 32'(ai) >= MAX_ATOMS) begin
            if (32'(acount) >= MAX_ATOMS) begin
              give(8'd0, ST_TABLE_FULL, 16'd0); state <= S_IDLE;
            end else state <= S_FIN;   // o_rd becomes end[acount]
          end else state <= S_IB;
        end
        S_IB: begin start <= o_rd; state <= S_IC; end
        S_IC: begin
          if (o_rd - start == len_o) begin
            k <= '0; rd_pend <= 1'b0; state <= S_CMP;
          end else begin ai <= ai + 1'b1; state <= S_IA; end
        end
        S_CMP: begin
          if (rd_pend && b_rd != p_rd) begin
            ai <= ai + 1'b1; state <= S_IA;
          end else if (k == len_o[LW:0]) begin
            give(8'(FIRST_ID + 32'(ai)), ST_FOUND, 16'd0); state <= S_IDLE;
          end else if (32'(start + OW'(k)) >= POOL_BYTES) begin
            ai <= ai + 1'b1; state <= S_IA;
          end else begin
            k <= k + 1'b1; rd_pend <= 1'b1;
          end
        end
        S_FIN: begin
          start <= o_rd;
          if ({1'b0, o_rd} + {1'b0, len_o} > {1'b0, limit_eff}) begin
            give(8'd0, ST_POOL_FULL, 16'({1'b0, o_rd} + {1'b0, len_o}));
            state <= S_IDLE;
          end else begin k <= '0; rd_pend <= 1'b0; state <= S_CPY; end
        end
        S_CPY: begin
          if (k == len_o[LW:0] + 1'b1) begin
            give(8'(FIRST_ID + 32'(acount)), ST_ADDED, 16'd0);
            acount <= acount + 1'b1; rd_pend <= 1'b0; state <= S_IDLE;
          end else begin
            k <= k + 1'b1; rd_pend <= (k < len_o[LW:0]);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_count: assert property (@(posedge clk) disable iff (rst)
    32'(acount) <= MAX_ATOMS) else $error("atom count overrun");
  a_len: assert property (@(posedge clk) disable iff (rst)
    32'(blen) <= MAX_STRING_BYTES) else $error("builder overrun");
endmodule
`default_nettype wire

// ===== tb/tb_string_atom_interner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_string_atom_interner
// Drives builder requests (append, trim, intern, pool reset, clear) into the
// interner with random gaps and output stalls. A scoreboard keeps its own
// copy of builder, atom table and pool, and checks every intern answer.
// ----------------------------------------------------------------------------
`default_nettype none

// Scoreboard: shadow copy of the interner and a queue of pending answers.
class interner_scoreboard;
  typedef struct packed {
    logic [7:0]  atom_id;
    logic [2:0]  status;
    logic [15:0] size_reported;
  } answer_t;

  logic [13:0] pool_limit;
  logic [7:0]  text_buf[sai_pkg::MAX_STRING_BYTES_DEF];
  int          text_len;
  bit          text_over;
  int          pushed;
  int          atom_cnt;
  int          ends[sai_pkg::MAX_ATOMS_DEF + 1];
  logic [7:0]  pool[sai_pkg::POOL_BYTES_DEF];
  answer_t     pending[$];
  int          errors;

  function void reset_state();
    pool_limit = sai_pkg::POOL_LIMIT_RESET;
    text_len = 0;
    text_over = 0;
    pushed = 0;
    atom_cnt = 0;
    ends[0] = 0;
    pending.delete();
  endfunction

  function answer_t lookup();
    answer_t a;
    int      lim;
    int      start;
    int      k;
    int      freep;
    a = '0;
    lim = (pool_limit < sai_pkg::POOL_BYTES_DEF) ? pool_limit : sai_pkg::POOL_BYTES_DEF;
    if (text_over) begin
      a.status = sai_pkg::ST_TOO_LONG;
      a.size_reported = pushed[15:0];
      return a;
    end
    if (text_len == 0) begin
      a.status = sai_pkg::ST_EMPTY;
      return a;
    end
    for (int i = 0; i < atom_cnt; i++) begin
      start = ends[i];
      if (ends[i + 1] - start != text_len) continue;
      for (k = 0; k < text_len; k++)
        if (pool[start + k] != text_buf[k]) break;
      if (k == text_len) begin
        a.atom_id = 8'(sai_pkg::FIRST_ID_DEF + i);
        a.status = sai_pkg::ST_FOUND;
        return a;
      end
    end
    if (atom_cnt >= sai_pkg::MAX_ATOMS_DEF) begin
      a.status = sai_pkg::ST_TABLE_FULL;
      return a;
    end
    freep = ends[atom_cnt];
    if (freep + text_len > lim) begin
      a.status = sai_pkg::ST_POOL_FULL;
      a.size_reported = 16'(freep + text_len);
      return a;
    end
    for (k = 0; k < text_len; k++) pool[freep + k] = text_buf[k];
    ends[atom_cnt + 1] = freep + text_len;
    a.atom_id = 8'(sai_pkg::FIRST_ID_DEF + atom_cnt);
    a.status = sai_pkg::ST_ADDED;
    atom_cnt++;
    return a;
  endfunction

  // Note an accepted request and update the shadow state.
  function void note_request(logic [2:0] op, logic [7:0] b);
    int lead;
    lead = 0;
    case (op)
      sai_pkg::OP_APPEND: begin
        if (pushed < 65535) pushed++;
        if (text_len >= sai_pkg::MAX_STRING_BYTES_DEF) text_over = 1;
        else begin
          text_buf[text_len] = b;
          text_len++;
        end
      end
      sai_pkg::OP_TRIM: begin
        while (text_len > 0 && text_buf[text_len - 1] == sai_pkg::SPACE_BYTE) text_len--;
        while (lead < text_len && text_buf[lead] == sai_pkg::SPACE_BYTE) lead++;
        if (lead > 0) begin
          for (int k = 0; lead + k < text_len; k++) text_buf[k] = text_buf[lead + k];
          text_len -= lead;
        end
      end
      sai_pkg::OP_INTERN: pending.push_back(lookup());
      sai_pkg::OP_RESET_POOL: begin
        atom_cnt = 0;
        ends[0] = 0;
      end
      sai_pkg::OP_CLEAR: begin
        text_len = 0;
        text_over = 0;
        pushed = 0;
      end
      default: ;
    endcase
  endfunction

  function void report(string msg);
    $display("MISMATCH %0t: %s", $time, msg);
    errors++;
  endfunction

  // Compare one accepted answer with the oldest pending one.
  function void check_answer(logic [7:0] id, logic [2:0] st, logic [15:0] sz);
    answer_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected answer id=%0d st=%0d", id, st));
      return;
    end
    e = pending.pop_front();
    if (id !== e.atom_id) report($sformatf("atom_id %0d, want %0d", id, e.atom_id));
    if (st !== e.status) report($sformatf("status %0d, want %0d", st, e.status));
    if (sz !== e.size_reported)
      report($sformatf("size_reported %0d, want %0d", sz, e.size_reported));
  endfunction
endclass

module tb_string_atom_interner;
  import sai_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [13:0] cfg_wdata = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  opcode = OP_APPEND;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [7:0]  atom_id;
  logic [2:0]  status;
  logic [15:0] size_reported;

  interner_scoreboard sb = new();
  bit sink_hold;   // long receiver hold-off, to back the block up

  string_atom_interner dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .atom_id(atom_id), .status(status),
    .size_reported(size_reported)
  );

  always #5 clk = ~clk;

  // Mostly no gap at all, often a short one, sometimes a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request and hold it until the handshake completes. Valid
  // stays high after the handshake so that the next request can follow
  // straight on; a gap or idle_input drops it.
  task automatic send_request(logic [2:0] op, logic [7:0] b, bit may_idle = 1);
    int g;
    g = may_idle ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, b);
  endtask

  // Drop valid after the last request of a burst.
  task automatic idle_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(OP_APPEND, s[i]);
  endtask

  // Wait until every answer is back, plus slack for the sequencer.
  task automatic wait_idle();
    idle_input();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_limit(logic [13:0] v);
    wait_idle();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.pool_limit = v;
  endtask

  // Random string from a small alphabet so repeats (found) are common.
  task automatic send_word(int maxlen);
    int n;
    n = $urandom_range(1, maxlen);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: send_request(OP_APPEND, SPACE_BYTE);
        1: send_request(OP_APPEND, 8'($urandom));
        default: send_request(OP_APPEND, 8'($urandom_range(8'h61, 8'h63)));
      endcase
    end
  endtask

  // Receiver: random stalls, plus the forced hold-off.
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= !sink_hold && ($urandom_range(0, 3) != 0);
    if (!rst && out_valid && out_ready) sb.check_answer(atom_id, status, size_reported);
  end

  initial begin
    int n;
    sb.reset_state();
    sink_hold = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty, simple add, found, trim, unused opcodes.
    send_request(OP_INTERN, 8'h00);
    send_text("  ab ");
    send_request(OP_TRIM, 8'h00);
    send_request(OP_INTERN, 8'h00);
    send_request(OP_INTERN, 8'h00);
    send_request(OP_CLEAR, 8'hFF);
    send_request(3'd5, 8'h00);
    send_request(3'd6, 8'hAA);
    send_request(3'd7, 8'h55);
    send_request(OP_APPEND, 8'hFF);
    send_request(OP_APPEND, 8'h00);
    send_request(OP_INTERN, 8'h00);
    send_request(OP_RESET_POOL, 8'h00);
    send_request(OP_INTERN, 8'h00);
    send_request(OP_CLEAR, 8'h00);
    send_text("   ");
    send_request(OP_TRIM, 8'h00);
    send_request(OP_INTERN, 8'h00);
    send_request(OP_CLEAR, 8'h00);

    // Pool limit extremes: zero and tiny limits force pool full.
    write_limit(14'd0);
    send_text("x");
    send_request(OP_INTERN, 8'h00);
    write_limit(14'd3);
    send_request(OP_INTERN, 8'h00);
    send_request(OP_CLEAR, 8'h00);
    send_text("yyy");
    send_request(OP_INTERN, 8'h00);
    send_request(OP_CLEAR, 8'h00);
    write_limit(14'h3FFF);

    // Hold the receiver off while interns keep arriving.
    sink_hold = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        sink_hold = 0;
      end
      begin
        for (int i = 0; i < 6; i++) begin
          send_request(OP_CLEAR, 8'h00);
          send_word(4);
          send_request(OP_INTERN, 8'h00);
        end
        idle_input();
      end
    join

    // Fill the atom table: each chunk grows one builder a byte at a time
    // and interns every prefix; chunks start on different bytes. The last
    // chunk overruns the table, then keeps growing until the builder
    // overflows.
    send_request(OP_RESET_POOL, 8'h00);
    for (int c = 0; c < 3; c++) begin
      n = (c == 2) ? 117 : 36;
      send_request(OP_CLEAR, 8'h00, 0);
      for (int i = 0; i < n; i++) begin
        send_request(OP_APPEND, 8'(c * 117 + i), 0);
        send_request(OP_INTERN, 8'h00, 0);
      end
    end
    for (int i = 0; i < 140; i++) send_request(OP_APPEND, 8'(i), 0);
    send_request(OP_INTERN, 8'h00);
    send_request(OP_CLEAR, 8'h00);
    send_request(OP_RESET_POOL, 8'h00);

    // Random phases at several limits.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: write_limit(POOL_LIMIT_RESET);
        1: write_limit(14'd40);
        default: write_limit(14'd8192);
      endcase
      for (int j = 0; j < 5; j++) begin
        case ($urandom_range(0, 9))
          0: send_request(OP_RESET_POOL, 8'($urandom));
          1: send_request(3'($urandom_range(5, 7)), 8'($urandom));
          2: send_request(OP_APPEND, 8'($urandom));
          default: begin
            send_request(OP_CLEAR, 8'($urandom));
            send_word(6);
            if ($urandom_range(0, 1)) send_request(OP_TRIM, 8'($urandom));
            send_request(OP_INTERN, 8'($urandom));
          end
        endcase
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Testbench completed without errors");
    else begin
      if (sb.pending.size() != 0) sb.report("answers still outstanding at the end");
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
